/* hw/rtl/ggp_pkg.sv */
// ----------------------------------------------------------------------------
// ggp_pkg - granular grain player shared definitions
// Sizes, sequencer states, divider request and response types and envelope function.
// ----------------------------------------------------------------------------
package ggp_pkg;

  localparam int SLOTS      = 256;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int SRC_DEPTH  = 131072;
  localparam int SRC_W      = $clog2(SRC_DEPTH);
  localparam int ENV_DEPTH  = 2048;
  localparam int ENV_W      = $clog2(ENV_DEPTH);
  localparam int ENV_SHIFT  = 2 * ENV_W - 17;
  localparam int POS_W      = 17;
  localparam int GRAIN_W    = 3 * POS_W;
  localparam int CNT_W      = SLOT_W + 1;
  localparam int ACC_W      = 40;

  // Divider sizes
  localparam int DIV_REM_W  = 24;
  localparam int DIV_LOW_W  = 18;
  localparam int DIV_QUO_W  = 18;
  localparam int DIV_CNT_W  = 5;
  localparam int IDX_QBITS  = ENV_W + 1;
  localparam int FIN_QBITS  = 18;

  // Register indexes
  localparam logic [2:0] REG_WINDOW    = 3'd0;
  localparam logic [2:0] REG_RANGE_ST  = 3'd1;
  localparam logic [2:0] REG_RANGE_END = 3'd2;
  localparam logic [2:0] REG_BUF_SIZE  = 3'd3;
  localparam logic [2:0] REG_ONSET     = 3'd4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACT_A,
    ST_ACT_B,
    ST_SEARCH,
    ST_MIX_GO,
    ST_MIX_CHK,
    ST_MIX_RD,
    ST_MIX_DIV,
    ST_MIX_MUL,
    ST_MIX_ACC,
    ST_FIN,
    ST_FIN_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_REM_W-1:0]  rem_init;
    logic [DIV_LOW_W-1:0]  low;
    logic [DIV_REM_W-1:0]  divisor;
    logic [DIV_CNT_W-1:0]  nbits;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_QUO_W-1:0]  quo;
  } div_rsp_t;

  // Parabola 4x(1-x) in Q1.15, rounded half up and capped
  function automatic logic [15:0] env_val(input logic [ENV_W-1:0] i);
    logic [ENV_W:0]     comp;
    logic [2*ENV_W+1:0] prod;
    logic [2*ENV_W+1:0] v;
    comp = ENV_W'(0) + (ENV_W+1)'(ENV_DEPTH) - {1'b0, i};
    prod = (2*ENV_W+2)'({1'b0, i}) * (2*ENV_W+2)'(comp);
    v    = (prod + (2*ENV_W+2)'(1 << (ENV_SHIFT - 1))) >> ENV_SHIFT;
    env_val = (v > (2*ENV_W+2)'(32767)) ? 16'd32767 : v[15:0];
  endfunction

endpackage

/* hw/rtl/ggp_ram.sv */
// ----------------------------------------------------------------------------
// ggp_ram - generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ggp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/ggp_div.sv */
// ----------------------------------------------------------------------------
// ggp_div - shared restoring divider
// Produces one quotient bit per cycle; the caller preloads the upper
// dividend part as a partial remainder below the divisor.
// ----------------------------------------------------------------------------
module ggp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ggp_pkg::div_req_t req,
  output ggp_pkg::div_rsp_t rsp
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [ggp_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ggp_pkg::DIV_REM_W-1:0]  rem_r, rem_nxt;
  logic [ggp_pkg::DIV_LOW_W-1:0]  low_r, low_nxt;
  logic [ggp_pkg::DIV_REM_W-1:0]  dvs_r, dvs_nxt;
  logic [ggp_pkg::DIV_QUO_W-1:0]  quo_r, quo_nxt;
  logic [ggp_pkg::DIV_REM_W:0]    cat;
  logic [ggp_pkg::DIV_REM_W+1:0]  diff;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  // Shift in one dividend bit, subtract when it fits
  always_comb begin
    cat      = {rem_r, low_r[ggp_pkg::DIV_LOW_W-1]};
    diff     = {1'b0, cat} - {2'b00, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.nbits;
      rem_nxt  = req.rem_init;
      low_nxt  = req.low;
      dvs_nxt  = req.divisor;
      quo_nxt  = '0;
    end else if (busy_r) begin
      low_nxt = {low_r[ggp_pkg::DIV_LOW_W-2:0], 1'b0};
      if (!diff[ggp_pkg::DIV_REM_W+1]) begin
        rem_nxt = diff[ggp_pkg::DIV_REM_W-1:0];
        quo_nxt = {quo_r[ggp_pkg::DIV_QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = cat[ggp_pkg::DIV_REM_W-1:0];
        quo_nxt = {quo_r[ggp_pkg::DIV_QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ggp_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

/* hw/rtl/granular_grain_player_top.sv */
// ----------------------------------------------------------------------------
// granular_grain_player_top - mono granular grain player
// Load items fill the source memory; tick items place grains and mix one
// enveloped sample per active grain through a shared divider.
// ----------------------------------------------------------------------------
// Load item: no result. Tick item: optional placement and free-slot search,
// then a visit to each of the 256 slots (an active grain waits on the index
// division), then the final division. A result still waiting at the output
// holds the next tick before its final division. Synchronous active-low
// reset clears control state and the valid bits and loads the configuration
// defaults; payload registers are not reset, and the grain memory needs no
// clearing pass.
module granular_grain_player_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [16:0] in_load_addr,
  input  logic signed [15:0] in_load_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_sample,
  output logic [8:0]  out_active_grains,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data
);

  ggp_pkg::state_t state_r, state_nxt;

  logic [16:0] window_r;
  logic [17:0] range_st_r, range_end_r, buf_size_r;
  logic [14:0] onset_r;

  logic [ggp_pkg::SLOTS-1:0]  valid_r, valid_nxt;
  logic [ggp_pkg::CNT_W-1:0]  active_r, active_nxt;
  logic [ggp_pkg::CNT_W-1:0]  snap_r, snap_nxt;
  logic [ggp_pkg::SLOT_W-1:0] search_r, search_nxt;
  logic [ggp_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [17:0]                nstart_r, nstart_nxt;
  logic [14:0]                cdown_r, cdown_nxt;
  logic                       out_valid_r, out_valid_nxt;

  logic [17:0] maxb_r, maxb_nxt, minb_r, minb_nxt;
  logic [16:0] gstart_r, gstart_nxt, gend_r, gend_nxt;
  logic [16:0] pos_r, pos_nxt, end_r, end_nxt, len_r, len_nxt;
  logic [15:0] env_r, env_nxt;
  logic signed [31:0] prod_r, prod_nxt;
  logic signed [ggp_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic signed [15:0] osmp_r, osmp_nxt;
  logic [8:0] ogr_r, ogr_nxt;

  // RAM ports
  logic                        src_we;
  logic [ggp_pkg::SRC_W-1:0]   src_raddr;
  logic signed [15:0]          src_rdata;
  logic                        g_we;
  logic [ggp_pkg::SLOT_W-1:0]  g_addr;
  logic [ggp_pkg::GRAIN_W-1:0] g_wdata, g_rdata;

  ggp_pkg::div_req_t div_req;
  ggp_pkg::div_rsp_t div_rsp;

  // Combinational helpers
  logic [17:0] mx_a, mx_b, st_c;
  logic [18:0] end_w, nxt_w;
  logic        ins;
  logic [16:0] g_pos, g_end, g_len, len1;
  logic [29:0] num;
  logic [ggp_pkg::ENV_W:0] idx;
  logic [ggp_pkg::ACC_W-1:0] mag, mval;
  logic [23:0] den;
  logic [ggp_pkg::DIV_QUO_W-1:0] q;

  ggp_ram #(.WIDTH(16), .DEPTH(ggp_pkg::SRC_DEPTH)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (in_load_addr[ggp_pkg::SRC_W-1:0]),
    .wdata (in_load_sample),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  ggp_ram #(.WIDTH(ggp_pkg::GRAIN_W), .DEPTH(ggp_pkg::SLOTS)) u_grain_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_addr),
    .wdata (g_wdata),
    .raddr (g_addr),
    .rdata (g_rdata)
  );

  ggp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= 17'd2400;
      range_st_r  <= 18'd0;
      range_end_r <= 18'd131072;
      buf_size_r  <= 18'd131072;
      onset_r     <= 15'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        ggp_pkg::REG_WINDOW:    window_r    <= cfg_data[16:0];
        ggp_pkg::REG_RANGE_ST:  range_st_r  <= cfg_data;
        ggp_pkg::REG_RANGE_END: range_end_r <= cfg_data;
        ggp_pkg::REG_BUF_SIZE:  buf_size_r  <= cfg_data;
        ggp_pkg::REG_ONSET:     onset_r     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ggp_pkg::ST_IDLE;
      valid_r     <= '0;
      active_r    <= '0;
      snap_r      <= '0;
      search_r    <= '0;
      slot_r      <= '0;
      nstart_r    <= '0;
      cdown_r     <= 15'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      active_r    <= active_nxt;
      snap_r      <= snap_nxt;
      search_r    <= search_nxt;
      slot_r      <= slot_nxt;
      nstart_r    <= nstart_nxt;
      cdown_r     <= cdown_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    maxb_r   <= maxb_nxt;
    minb_r   <= minb_nxt;
    gstart_r <= gstart_nxt;
    gend_r   <= gend_nxt;
    pos_r    <= pos_nxt;
    end_r    <= end_nxt;
    len_r    <= len_nxt;
    env_r    <= env_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    osmp_r   <= osmp_nxt;
    ogr_r    <= ogr_nxt;
  end

  assign {g_pos, g_end, g_len} = g_rdata;
  assign src_raddr = pos_r[ggp_pkg::SRC_W-1:0];

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    active_nxt    = active_r;
    snap_nxt      = snap_r;
    search_nxt    = search_r;
    slot_nxt      = slot_r;
    nstart_nxt    = nstart_r;
    cdown_nxt     = cdown_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    maxb_nxt      = maxb_r;
    minb_nxt      = minb_r;
    gstart_nxt    = gstart_r;
    gend_nxt      = gend_r;
    pos_nxt       = pos_r;
    end_nxt       = end_r;
    len_nxt       = len_r;
    env_nxt       = env_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    osmp_nxt      = osmp_r;
    ogr_nxt       = ogr_r;
    in_ready      = 1'b0;
    src_we        = 1'b0;
    g_we          = 1'b0;
    g_addr        = slot_r;
    g_wdata       = {gstart_r, gend_r, gend_r - gstart_r};
    div_req       = '0;

    mx_a  = (range_end_r < buf_size_r) ? range_end_r : buf_size_r;
    mx_b  = (mx_a < 18'(ggp_pkg::SRC_DEPTH)) ? mx_a : 18'(ggp_pkg::SRC_DEPTH);
    st_c  = (nstart_r >= maxb_r || nstart_r < minb_r) ? minb_r : nstart_r;
    end_w = {1'b0, st_c} + {2'b00, window_r};
    nxt_w = end_w;
    ins   = 1'b0;
    len1  = (g_len == '0) ? 17'd1 : g_len;
    num   = 30'(g_end - g_pos) * 30'd4094 + 30'(len1);
    idx   = div_rsp.quo[ggp_pkg::ENV_W:0];
    mag   = acc_r[ggp_pkg::ACC_W-1] ? -acc_r : acc_r;
    den   = {snap_r, 15'd0};
    mval  = mag + ggp_pkg::ACC_W'(den >> 1);
    q     = div_rsp.quo;

    case (state_r)
      ggp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == ggp_pkg::OP_LOAD) begin
            src_we = 1'b1;
          end else begin
            cdown_nxt = cdown_r - 1'b1;
            if (cdown_r == 15'd1) begin
              cdown_nxt = onset_r;
              state_nxt = ggp_pkg::ST_ACT_A;
            end else begin
              state_nxt = ggp_pkg::ST_MIX_GO;
            end
          end
        end
      end

      // Clamp bounds for placement
      ggp_pkg::ST_ACT_A: begin
        maxb_nxt = mx_b;
        if (range_st_r >= mx_b) begin
          minb_nxt = (mx_b >= 18'd2) ? mx_b - 18'd2 : 18'd0;
        end else begin
          minb_nxt = range_st_r;
        end
        state_nxt = ggp_pkg::ST_ACT_B;
      end

      // Place the grain and advance the moving start
      ggp_pkg::ST_ACT_B: begin
        if (end_w >= {1'b0, maxb_r}) begin
          ins      = (maxb_r != '0) && (st_c < maxb_r - 18'd1);
          gend_nxt = 17'(maxb_r - 18'd1);
        end else begin
          ins      = ({1'b0, st_c} < end_w);
          gend_nxt = end_w[16:0];
        end
        gstart_nxt = st_c[16:0];
        nstart_nxt = (nxt_w >= {1'b0, range_end_r}) ? minb_r : nxt_w[17:0];
        if (ins) begin
          slot_nxt  = search_r;
          state_nxt = ggp_pkg::ST_SEARCH;
        end else begin
          state_nxt = ggp_pkg::ST_MIX_GO;
        end
      end

      // Look for a free slot, one per cycle
      ggp_pkg::ST_SEARCH: begin
        if (!valid_r[slot_r]) begin
          g_we             = 1'b1;
          valid_nxt[slot_r] = 1'b1;
          active_nxt       = active_r + 1'b1;
          search_nxt       = slot_r + 1'b1;
          state_nxt        = ggp_pkg::ST_MIX_GO;
        end else if (slot_r == ggp_pkg::SLOT_W'(ggp_pkg::SLOTS - 1)) begin
          state_nxt = ggp_pkg::ST_MIX_GO;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end

      ggp_pkg::ST_MIX_GO: begin
        snap_nxt  = active_r;
        slot_nxt  = '0;
        acc_nxt   = '0;
        state_nxt = ggp_pkg::ST_MIX_CHK;
      end

      // Skip free slots, fetch state of active ones
      ggp_pkg::ST_MIX_CHK: begin
        if (valid_r[slot_r]) begin
          state_nxt = ggp_pkg::ST_MIX_RD;
        end else if (slot_r == ggp_pkg::SLOT_W'(ggp_pkg::SLOTS - 1)) begin
          state_nxt = ggp_pkg::ST_FIN;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end

      // Free finished grains, else start the envelope index division
      ggp_pkg::ST_MIX_RD: begin
        pos_nxt = g_pos;
        end_nxt = g_end;
        len_nxt = g_len;
        if (g_pos == g_end) begin
          valid_nxt[slot_r] = 1'b0;
          if (active_r != '0) begin
            active_nxt = active_r - 1'b1;
          end
          if (slot_r == ggp_pkg::SLOT_W'(ggp_pkg::SLOTS - 1)) begin
            state_nxt = ggp_pkg::ST_FIN;
          end else begin
            slot_nxt  = slot_r + 1'b1;
            state_nxt = ggp_pkg::ST_MIX_CHK;
          end
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = ggp_pkg::DIV_REM_W'(num >> ggp_pkg::IDX_QBITS);
          div_req.low      = {num[ggp_pkg::IDX_QBITS-1:0],
                              (ggp_pkg::DIV_LOW_W - ggp_pkg::IDX_QBITS)'(0)};
          div_req.divisor  = ggp_pkg::DIV_REM_W'({len1, 1'b0});
          div_req.nbits    = ggp_pkg::DIV_CNT_W'(ggp_pkg::IDX_QBITS);
          state_nxt        = ggp_pkg::ST_MIX_DIV;
        end
      end

      // Clamp the index and look up the envelope
      ggp_pkg::ST_MIX_DIV: begin
        if (div_rsp.done) begin
          if (idx >= (ggp_pkg::ENV_W+1)'(ggp_pkg::ENV_DEPTH - 1)) begin
            env_nxt = ggp_pkg::env_val(ggp_pkg::ENV_W'(ggp_pkg::ENV_DEPTH - 2));
          end else begin
            env_nxt = ggp_pkg::env_val(idx[ggp_pkg::ENV_W-1:0]);
          end
          state_nxt = ggp_pkg::ST_MIX_MUL;
        end
      end

      ggp_pkg::ST_MIX_MUL: begin
        prod_nxt  = 32'(src_rdata) * $signed({16'd0, env_r});
        state_nxt = ggp_pkg::ST_MIX_ACC;
      end

      // Accumulate and advance the grain position
      ggp_pkg::ST_MIX_ACC: begin
        acc_nxt = acc_r + ggp_pkg::ACC_W'(prod_r);
        g_we    = 1'b1;
        g_wdata = {pos_r + 17'd1, end_r, len_r};
        if (slot_r == ggp_pkg::SLOT_W'(ggp_pkg::SLOTS - 1)) begin
          state_nxt = ggp_pkg::ST_FIN;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          state_nxt = ggp_pkg::ST_MIX_CHK;
        end
      end

      // Normalize by the active count; hold while the last item still waits
      ggp_pkg::ST_FIN: begin
        if (out_valid_r && !out_ready) begin
          state_nxt = ggp_pkg::ST_FIN;
        end else if (snap_r == '0) begin
          osmp_nxt  = '0;
          state_nxt = ggp_pkg::ST_OUT;
        end else begin
          div_req.start    = 1'b1;
          div_req.rem_init = ggp_pkg::DIV_REM_W'(mval >> ggp_pkg::FIN_QBITS);
          div_req.low      = mval[ggp_pkg::FIN_QBITS-1:0];
          div_req.divisor  = den;
          div_req.nbits    = ggp_pkg::DIV_CNT_W'(ggp_pkg::FIN_QBITS);
          state_nxt        = ggp_pkg::ST_FIN_DIV;
        end
      end

      // Restore sign and saturate
      ggp_pkg::ST_FIN_DIV: begin
        if (div_rsp.done) begin
          if (acc_r[ggp_pkg::ACC_W-1]) begin
            osmp_nxt = (q > 18'd32768) ? 16'sh8000 : -$signed(q[15:0]);
          end else begin
            osmp_nxt = (q > 18'd32767) ? 16'sh7fff : $signed(q[15:0]);
          end
          state_nxt = ggp_pkg::ST_OUT;
        end
      end

      // Hand the item to the output register once it is free
      ggp_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          ogr_nxt       = 9'(active_r);
          state_nxt     = ggp_pkg::ST_IDLE;
        end
      end

      default: state_nxt = ggp_pkg::ST_IDLE;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_sample        = osmp_r;
  assign out_active_grains = ogr_r;

endmodule
